@@ design/msgs_pkg.sv @@
// Shared types and constants for the masked square gradient sum block.
// Holds the register map, compare mode codes, the line store entry layout
// and the small helper functions. No dependencies.
package msgs_pkg;

    // Configuration register widths.
    localparam int CFG_DIM_W  = 13;
    localparam int CFG_VAL_W  = 8;
    localparam int CFG_MODE_W = 3;
    localparam int PIX_W      = 8;
    localparam int ACC_W      = 42;
    localparam int SUM_W      = 41;
    localparam int GRAD_W     = 17;

    // Register index codes, taken from paddr[3:2].
    localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_COMPARE_VALUE = 2'd2;
    localparam logic [1:0] REG_COMPARE_MODE  = 2'd3;

    // Compare mode codes: mask op value, unsigned.
    localparam logic [CFG_MODE_W-1:0] CMP_EQ = 3'd0;
    localparam logic [CFG_MODE_W-1:0] CMP_NE = 3'd1;
    localparam logic [CFG_MODE_W-1:0] CMP_GT = 3'd2;
    localparam logic [CFG_MODE_W-1:0] CMP_GE = 3'd3;
    localparam logic [CFG_MODE_W-1:0] CMP_LT = 3'd4;
    localparam logic [CFG_MODE_W-1:0] CMP_LE = 3'd5;

    // One column of the line store: two source rows and the mask row.
    typedef struct packed {
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] middle;
        logic [PIX_W-1:0] mask;
    } line_entry_t;

    localparam int ENTRY_W = $bits(line_entry_t);

    // First pipeline stage: absolute differences and flags.
    typedef struct packed {
        logic             qual;
        logic             last;
        logic [PIX_W-1:0] dh;
        logic [PIX_W-1:0] dv;
    } diff_stage_t;

    // Second pipeline stage: gradient energy of one pixel.
    typedef struct packed {
        logic              qual;
        logic              last;
        logic [GRAD_W-1:0] grad;
    } grad_stage_t;

    // Absolute difference of two unsigned pixels.
    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Mask test; the two unused mode codes never pass.
    function automatic logic mask_pass(input logic [PIX_W-1:0]      m,
                                       input logic [CFG_VAL_W-1:0]  v,
                                       input logic [CFG_MODE_W-1:0] mode);
        logic res;
        case (mode)
            CMP_EQ:  res = (m == v);
            CMP_NE:  res = (m != v);
            CMP_GT:  res = (m > v);
            CMP_GE:  res = (m >= v);
            CMP_LT:  res = (m < v);
            CMP_LE:  res = (m <= v);
            default: res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

@@ design/msgs_ram.sv @@
// Generic simple dual port RAM with one write port and a registered read.
// Used for the line store of the masked square gradient sum block.
// No dependencies.
module msgs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wen,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     ren,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/masked_square_gradient_sum.sv @@
// Masked square gradient sum: sums (right-left)^2 + (below-above)^2 over
// the masked interior pixels of one raster frame and emits the total.
// Depends on msgs_pkg and msgs_ram.
//
// Usage: pixels enter in raster order on the input channel (pixel,
// mask_pixel, in_valid, in_stall), one transfer per clock while the
// block keeps in_stall low. Each frame yields one transfer of total_sum
// on the output channel through stage one, stage two and the output
// register after the last pixel of the frame is taken. Registers on the
// APB port set the frame geometry and the mask test; the user must see
// that they are written between frames, which the block does not enforce.
// Throughput is one pixel per clock while in_stall is low. The line
// store is a single RAM that is read two columns ahead of the incoming
// pixel and written at the incoming column, so each pixel costs one read
// and one write. After reset and after every register write, in_stall is
// high through ST_FILL0 and ST_FILL1 while the two prefetched columns are
// loaded again. The result sits in an output register until the receiver
// takes it; the block keeps taking pixels meanwhile, and holds off only
// the last pixel of the next frame while a result is still pending.
module masked_square_gradient_sum
    import msgs_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    // Input channel.
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [PIX_W-1:0]  pixel,
    input  logic [PIX_W-1:0]  mask_pixel,
    // Output channel.
    output logic              out_valid,
    input  logic              out_stall,
    output logic [SUM_W-1:0]  total_sum,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WCW = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int HCW = $clog2(MAX_HEIGHT + 1);

    // Prefetch sequencer codes.
    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_FILL0 = 2'd1;
    localparam logic [1:0] ST_FILL1 = 2'd2;

    logic [CFG_DIM_W-1:0]  width_cfg_reg;
    logic [CFG_DIM_W-1:0]  height_cfg_reg;
    logic [CFG_VAL_W-1:0]  cmp_value_reg;
    logic [CFG_MODE_W-1:0] cmp_mode_reg;

    logic [1:0]            fill_reg, fill_next;
    logic [CW-1:0]         col_reg, col_next;
    logic [RW-1:0]         row_reg, row_next;
    logic [PIX_W-1:0]      left_reg;
    line_entry_t           hold_reg;

    diff_stage_t           s1_reg;
    logic                  s1_valid_reg;
    grad_stage_t           s2_reg;
    logic                  s2_valid_reg;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic                  out_valid_reg;
    logic [SUM_W-1:0]      total_reg;

    logic                  cfg_write;
    logic                  in_accept;
    logic                  out_accept;
    logic [WCW-1:0]        width_eff;
    logic [WCW-1:0]        last_col_idx;
    logic [HCW-1:0]        height_eff;
    logic [HCW-1:0]        last_row_idx;
    logic                  last_col;
    logic                  last_row;
    logic                  last_pos;
    logic [CW-1:0]         pos1;
    logic [CW-1:0]         pos2;
    logic                  pos1_last;
    logic                  result_busy;

    logic                  ram_ren;
    logic [CW-1:0]         ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;
    line_entry_t           rd_entry;
    line_entry_t           wr_entry;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= CFG_DIM_W'(3);
            height_cfg_reg <= CFG_DIM_W'(3);
            cmp_value_reg  <= '0;
            cmp_mode_reg   <= CMP_EQ;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_FRAME_WIDTH:   width_cfg_reg  <= pwdata[CFG_DIM_W-1:0];
                REG_FRAME_HEIGHT:  height_cfg_reg <= pwdata[CFG_DIM_W-1:0];
                REG_COMPARE_VALUE: cmp_value_reg  <= pwdata[CFG_VAL_W-1:0];
                REG_COMPARE_MODE:  cmp_mode_reg   <= pwdata[CFG_MODE_W-1:0];
                default:           cmp_mode_reg   <= cmp_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_FRAME_WIDTH:   prdata = 32'(width_cfg_reg);
            REG_FRAME_HEIGHT:  prdata = 32'(height_cfg_reg);
            REG_COMPARE_VALUE: prdata = 32'(cmp_value_reg);
            REG_COMPARE_MODE:  prdata = 32'(cmp_mode_reg);
            default:           prdata = '0;
        endcase
    end

    // Effective frame geometry, clamped to the supported range.
    always_comb
    begin
        if (width_cfg_reg < CFG_DIM_W'(3))
        begin
            width_eff = WCW'(3);
        end
        else if (32'(width_cfg_reg) > MAX_WIDTH)
        begin
            width_eff = WCW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = WCW'(width_cfg_reg);
        end

        if (height_cfg_reg < CFG_DIM_W'(3))
        begin
            height_eff = HCW'(3);
        end
        else if (32'(height_cfg_reg) > MAX_HEIGHT)
        begin
            height_eff = HCW'(MAX_HEIGHT);
        end
        else
        begin
            height_eff = HCW'(height_cfg_reg);
        end
    end

    assign last_col_idx = width_eff - WCW'(1);
    assign last_row_idx = height_eff - HCW'(1);
    assign last_col     = WCW'(col_reg) >= last_col_idx;
    assign last_row     = HCW'(row_reg) >= last_row_idx;
    assign last_pos     = last_col && last_row;

    // The next two columns in raster order; they wrap at the row end.
    assign pos1      = last_col ? '0 : col_reg + CW'(1);
    assign pos1_last = WCW'(pos1) >= last_col_idx;
    assign pos2      = pos1_last ? '0 : pos1 + CW'(1);

    // Input handshake. Only one frame result may be in flight at a time.
    assign result_busy = out_valid_reg || (s1_valid_reg && s1_reg.last)
                       || (s2_valid_reg && s2_reg.last);
    assign in_stall    = (fill_reg != ST_RUN) || (last_pos && result_busy);
    assign in_accept   = in_valid && !in_stall;

    // Prefetch sequencer: reloads the current and next columns, then reads two columns ahead in ST_RUN.
    always_comb
    begin
        fill_next = fill_reg;
        ram_raddr = col_reg;
        unique case (fill_reg)
            ST_FILL0:
            begin
                ram_raddr = col_reg;
                fill_next = ST_FILL1;
            end
            ST_FILL1:
            begin
                ram_raddr = pos1;
                fill_next = ST_RUN;
            end
            ST_RUN:
            begin
                ram_raddr = pos2;
            end
            default:
            begin
                ram_raddr = col_reg;
                fill_next = ST_FILL0;
            end
        endcase
        if (cfg_write)
        begin
            fill_next = ST_FILL0;
        end
    end

    assign ram_ren = (fill_reg == ST_FILL0) || (fill_reg == ST_FILL1) || in_accept;

    // Line store: upper row, middle row and middle mask for each column.
    assign wr_entry = '{upper: hold_reg.middle, middle: pixel, mask: mask_pixel};
    assign rd_entry = line_entry_t'(ram_rdata);

    msgs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .wen   (in_accept),
        .waddr (col_reg),
        .wdata (wr_entry),
        .ren   (ram_ren),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Raster position.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_accept)
        begin
            if (!last_col)
            begin
                col_next = col_reg + CW'(1);
            end
            else
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= ST_FILL0;
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            if (in_accept)
            begin
                left_reg <= last_col ? '0 : hold_reg.middle;
            end
        end
    end

    // The current column entry moves out of the RAM read register.
    always_ff @(posedge clk)
    begin
        if ((fill_reg == ST_FILL1) || in_accept)
        begin
            hold_reg <= rd_entry;
        end
    end

    // Stage one: differences and the qualify test for the centre pixel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_reg.qual <= (row_reg >= RW'(2)) && (col_reg != '0) && !last_col
                        && mask_pass(hold_reg.mask, cmp_value_reg, cmp_mode_reg);
            s1_reg.last <= last_pos;
            s1_reg.dh   <= abs_diff(rd_entry.middle, left_reg);
            s1_reg.dv   <= abs_diff(pixel, hold_reg.upper);
        end
    end

    // Stage two: squares and their sum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_reg.qual <= s1_reg.qual;
            s2_reg.last <= s1_reg.last;
            s2_reg.grad <= GRAD_W'(s1_reg.dh) * GRAD_W'(s1_reg.dh)
                         + GRAD_W'(s1_reg.dv) * GRAD_W'(s1_reg.dv);
        end
    end

    // Accumulator and output register.
    assign acc_next   = acc_reg + ((s2_valid_reg && s2_reg.qual) ?
                                   ACC_W'(s2_reg.grad) : '0);
    assign out_accept = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_valid_reg && s2_reg.last)
            begin
                acc_reg       <= '0;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                acc_reg <= acc_next;
                if (out_accept)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s2_reg.last)
        begin
            total_reg <= acc_next[SUM_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign total_sum = total_reg;

    // A frame result never lands on a result that is still pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_reg.last) |-> !out_valid_reg)
        else $error("frame result overwrote a pending result");

    // No pixel is taken while the prefetch is being reloaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != ST_RUN) |-> in_stall)
        else $error("pixel taken during prefetch reload");

    // The prefetch read never targets the column being written.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> (ram_raddr != col_reg))
        else $error("line store read and write collide");

    // The last pixel of a frame produces a result through stage one, stage two and the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && last_pos) |=> ##2 out_valid_reg)
        else $error("frame result missing after last pixel");

endmodule

@@ sim/tb_masked_square_gradient_sum.sv @@
// Self-checking testbench for masked_square_gradient_sum: streams raster frames,
// predicts each frame's gradient energy total and checks every output transfer.
// Depends on msgs_pkg and the design files of the block.
`timescale 1ns / 100ps

module tb_masked_square_gradient_sum
    import msgs_pkg::*;
();

    localparam int MAX_DIM        = 4096;
    localparam int SETTLE_CYCLES  = 10;
    localparam int RANDOM_ITEMS   = 900;
    localparam int RANDOM_FRAMES  = 8;
    localparam int REPORT_LIMIT   = 10;
    localparam int TIMEOUT_CYCLES = 1000000;

    // Clock, reset and block ports; every input starts at a known value.
    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic [PIX_W-1:0]  pixel      = '0;
    logic [PIX_W-1:0]  mask_pixel = '0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic [SUM_W-1:0]  total_sum;
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [3:0]        paddr      = '0;
    logic [31:0]       pwdata     = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Shadow copy of the registers.
    logic [CFG_DIM_W-1:0]  width_reg;
    logic [CFG_DIM_W-1:0]  height_reg;
    logic [CFG_VAL_W-1:0]  cmp_value_reg;
    logic [CFG_MODE_W-1:0] cmp_mode_reg;

    // Predictor state: line stores, raster position, window and running energy.
    logic [PIX_W-1:0] upper_row   [MAX_DIM];
    logic [PIX_W-1:0] middle_row  [MAX_DIM];
    logic [PIX_W-1:0] middle_mask [MAX_DIM];
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [PIX_W-1:0] win_left;
    logic [PIX_W-1:0] win_mid;
    logic [PIX_W-1:0] win_right;
    logic [ACC_W-1:0] energy_acc;

    // Frame totals still owed by the block, oldest first.
    logic [SUM_W-1:0] expected_totals [$];

    int idle_pct;
    int stall_pct;
    int items_sent;
    int totals_seen;
    int error_count;

    masked_square_gradient_sum dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel      (pixel),
        .mask_pixel (mask_pixel),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .total_sum  (total_sum),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Clock with a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Effective frame dimension: small values act as 3, large ones as the maximum.
    function automatic int unsigned clamp_dim(input logic [CFG_DIM_W-1:0] v);
        if (v < 3)
            return 3;
        if (v > MAX_DIM)
            return MAX_DIM;
        return v;
    endfunction

    // Mask test of the current mode; the two spare codes never qualify.
    function automatic bit mask_ok(input logic [PIX_W-1:0] m);
        case (cmp_mode_reg)
            CMP_EQ:  return m == cmp_value_reg;
            CMP_NE:  return m != cmp_value_reg;
            CMP_GT:  return m > cmp_value_reg;
            CMP_GE:  return m >= cmp_value_reg;
            CMP_LT:  return m < cmp_value_reg;
            CMP_LE:  return m <= cmp_value_reg;
            default: return 1'b0;
        endcase
    endfunction

    function automatic int unsigned diff_squared(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        int unsigned d;
        d = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
        return d * d;
    endfunction

    // Advance the predictor by one accepted pixel; queue a total at frame end.
    task automatic predict_pixel(input logic [PIX_W-1:0] pix, input logic [PIX_W-1:0] mpix);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned ci;
        bit          last_col;
        bit          last_row;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        c = col_pos;
        r = row_pos;
        last_col = c >= w - 1;
        last_row = r >= h - 1;
        ci = c % MAX_DIM;
        win_mid = middle_row[ci];
        win_right = (c + 1 < MAX_DIM) ? middle_row[c + 1] : '0;
        // The centre one row up is interior and masked in: add its energy.
        if (r >= 2 && c >= 1 && !last_col && mask_ok(middle_mask[ci]))
            energy_acc = energy_acc + ACC_W'(diff_squared(win_right, win_left))
                                    + ACC_W'(diff_squared(pix, upper_row[ci]));
        upper_row[ci] = win_mid;
        middle_row[ci] = pix;
        middle_mask[ci] = mpix;
        win_left = win_mid;
        if (!last_col)
        begin
            col_pos = c + 1;
            return;
        end
        col_pos = 0;
        win_left = '0;
        if (!last_row)
        begin
            row_pos = r + 1;
            return;
        end
        row_pos = 0;
        expected_totals.push_back(energy_acc[SUM_W-1:0]);
        energy_acc = '0;
    endtask

    task automatic set_idling(input int sender, input int receiver);
        idle_pct = sender;
        stall_pct = receiver;
    endtask

    // Select one of the four idling phases by number.
    task automatic select_phase(input int phase);
        case (phase % 4)
            0:       set_idling(0, 0);
            1:       set_idling(57, 0);
            2:       set_idling(0, 57);
            default: set_idling(19, 19);
        endcase
    endtask

    // Register write: a setup phase and an access phase on the APB port.
    // The caller releases the port after its last write.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_FRAME_WIDTH:   width_reg = value[CFG_DIM_W-1:0];
            REG_FRAME_HEIGHT:  height_reg = value[CFG_DIM_W-1:0];
            REG_COMPARE_VALUE: cmp_value_reg = value[CFG_VAL_W-1:0];
            default:           cmp_mode_reg = value[CFG_MODE_W-1:0];
        endcase
    endtask

    task automatic configure(input logic [CFG_DIM_W-1:0] w, input logic [CFG_DIM_W-1:0] h,
                             input logic [CFG_VAL_W-1:0] v, input logic [CFG_MODE_W-1:0] m);
        write_reg(REG_FRAME_WIDTH, 32'(w));
        write_reg(REG_FRAME_HEIGHT, 32'(h));
        write_reg(REG_COMPARE_VALUE, 32'(v));
        write_reg(REG_COMPARE_MODE, 32'(m));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Drop valid, wait for every owed total, then let the pipeline drain.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_totals.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One input transfer, preceded by a random number of idle cycles.
    task automatic send_pixel(input logic [PIX_W-1:0] p, input logic [PIX_W-1:0] m);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel <= p;
        mask_pixel <= m;
        do
            @(posedge clk);
        while (in_stall);
        predict_pixel(p, m);
        items_sent++;
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel();
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return PIX_W'($urandom_range(255));
    endfunction

    // Mask values cluster around the compare value so every mode sees both outcomes.
    function automatic logic [PIX_W-1:0] rand_mask();
        case ($urandom_range(3))
            0:       return cmp_value_reg;
            1:       return cmp_value_reg + 8'd1;
            2:       return cmp_value_reg - 8'd1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    task automatic send_frame();
        int unsigned w;
        int unsigned h;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        repeat (w * h) send_pixel(rand_pixel(), rand_mask());
    endtask

    // Directed: a 3x3 frame at reset settings with the largest possible gradient.
    task automatic test_reset_defaults();
        logic [PIX_W-1:0] pix [9];
        logic [PIX_W-1:0] msk [9];
        set_idling(0, 0);
        foreach (pix[i])
        begin
            pix[i] = rand_pixel();
            msk[i] = PIX_W'($urandom_range(1, 255));
        end
        pix[1] = 8'h00;
        pix[3] = 8'h00;
        pix[5] = 8'hFF;
        pix[7] = 8'hFF;
        msk[4] = 8'h00;
        foreach (pix[i])
            send_pixel(pix[i], msk[i]);
        // Same frame again, inverted, with the centre masked out.
        msk[4] = 8'hFF;
        foreach (pix[i])
            send_pixel(~pix[i], msk[i]);
        settle();
    endtask

    // Directed: dimensions below the minimum and a spare compare code.
    task automatic test_clamp_low_and_spare_mode();
        set_idling(19, 19);
        configure(13'd0, 13'd1, 8'h00, 3'd7);
        repeat (9) send_pixel(rand_pixel(), 8'h00);
        settle();
    endtask

    // Every compare mode, with values at both ends and in the middle.
    task automatic test_compare_modes();
        logic [CFG_VAL_W-1:0] v;
        for (int mode = 0; mode < 8; mode++)
        begin
            select_phase(mode);
            case (mode % 3)
                0:       v = 8'h00;
                1:       v = 8'hFF;
                default: v = 8'h80;
            endcase
            configure(13'd4, 13'd3, v, CFG_MODE_W'(mode));
            send_frame();
            settle();
        end
    endtask

    // One wide, flat frame and one narrow, tall frame.
    task automatic test_geometry_extremes();
        set_idling(19, 19);
        configure(13'd64, 13'd3, 8'h80, CMP_NE);
        send_frame();
        settle();
        set_idling(0, 0);
        configure(13'd3, 13'd64, 8'h40, CMP_GE);
        send_frame();
        settle();
    endtask

    // Random frames with random settings; some frames follow back to back.
    task automatic test_random_frames();
        int frames;
        int start_items;
        logic [CFG_DIM_W-1:0] w;
        logic [CFG_DIM_W-1:0] h;
        logic [CFG_VAL_W-1:0] v;
        frames = 0;
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS || frames < RANDOM_FRAMES)
        begin
            select_phase(frames);
            if (frames == 0 || $urandom_range(1))
            begin
                settle();
                w = ($urandom_range(9) == 0) ? CFG_DIM_W'($urandom_range(2))
                                             : CFG_DIM_W'($urandom_range(3, 24));
                h = ($urandom_range(9) == 0) ? CFG_DIM_W'($urandom_range(2))
                                             : CFG_DIM_W'($urandom_range(3, 10));
                case ($urandom_range(4))
                    0:       v = 8'h00;
                    1:       v = 8'hFF;
                    default: v = CFG_VAL_W'($urandom_range(255));
                endcase
                configure(w, h, v, CFG_MODE_W'($urandom_range(7)));
            end
            send_frame();
            frames++;
        end
        settle();
    endtask

    // Receiver: random stall, and a check of each accepted output transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                totals_seen++;
                if (expected_totals.size() == 0)
                begin
                    if (error_count < REPORT_LIMIT)
                        $display("unexpected total_sum transfer: actual %0d", total_sum);
                    error_count++;
                end
                else if (total_sum !== expected_totals[0])
                begin
                    if (error_count < REPORT_LIMIT)
                        $display("total_sum mismatch: expected %0d actual %0d",
                                 expected_totals[0], total_sum);
                    error_count++;
                    void'(expected_totals.pop_front());
                end
                else
                    void'(expected_totals.pop_front());
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Main sequence.
    initial
    begin
        width_reg = 13'd3;
        height_reg = 13'd3;
        cmp_value_reg = '0;
        cmp_mode_reg = CMP_EQ;
        col_pos = 0;
        row_pos = 0;
        win_left = '0;
        win_mid = '0;
        win_right = '0;
        energy_acc = '0;
        for (int i = 0; i < MAX_DIM; i++)
        begin
            upper_row[i] = '0;
            middle_row[i] = '0;
            middle_mask[i] = '0;
        end
        items_sent = 0;
        totals_seen = 0;
        error_count = 0;
        set_idling(0, 0);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_clamp_low_and_spare_mode();
        test_compare_modes();
        test_geometry_extremes();
        test_random_frames();

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog for a stuck handshake.
    initial
    begin
        #(TIMEOUT_CYCLES * 12);
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ masked_square_gradient_sum.f @@
design/msgs_pkg.sv
design/msgs_ram.sv
design/masked_square_gradient_sum.sv
sim/tb_masked_square_gradient_sum.sv
